// ===== rtl/nrce_pkg.sv =====
`default_nettype none

package nrce_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W     = 12;
    localparam int HIST_DEPTH  = 4;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int CNT_W       = 4;

    // Longest run code: the inline form, six prefix ones, length-1, nybble.
    localparam int          RUN_BITS_W    = 13;
    localparam logic [5:0]  INLINE_PREFIX = 6'h3F;
    localparam logic [3:0]  INLINE_LEN    = 4'd13;
    localparam logic [3:0]  MAX_CODE_LEN  = 4'd8;

    // Bit buffer of the packer: holds at most seven pending bits plus two full runs.
    localparam int ACC_W     = 40;
    localparam int ACC_CNT_W = 6;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_DATA = 2'd1;
    localparam logic [1:0] FUNC_EOS  = 2'd2;

    localparam logic REG_XOR_MODE = 1'b0;
    localparam logic REG_PAD      = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [6:0] entry_index;
        logic [7:0] entry_code;
        logic [3:0] entry_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic       vld;
        logic [3:0] digit;
        logic [2:0] len_m1;
    } run_evt_t;

    typedef struct packed {
        run_evt_t         evt;
        logic [3:0]       digit;
        logic [CNT_W-1:0] count;
    } step_t;

    // Stage between the run tracker and the packer.
    typedef struct packed {
        logic     eos;
        run_evt_t run0;
        run_evt_t run1;
    } stage_t;

    // Adds one nybble to the open run. At most one run closes per nybble.
    function automatic step_t nybble_step(logic [3:0] digit, logic [CNT_W-1:0] count,
                                          logic [3:0] n, logic [CNT_W-1:0] max_len);
        step_t            s;
        logic [CNT_W-1:0] c;
        s = '0;
        c = count;
        if (count != '0 && n != digit)
        begin
            s.evt.vld    = 1'b1;
            s.evt.digit  = digit;
            s.evt.len_m1 = 3'(count - CNT_W'(1));
            c            = '0;
        end
        c = c + CNT_W'(1);
        s.digit = n;
        if (c >= max_len)
        begin
            s.evt.vld    = 1'b1;
            s.evt.digit  = n;
            s.evt.len_m1 = 3'(c - CNT_W'(1));
            c            = '0;
        end
        s.count = c;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nybble_run_code_emitter_core.sv =====
// Nybble run code emitter.
// Input channel (item_valid, item_stall, item): an item either loads one entry
// of the 128-entry code table, carries one data byte, or ends the stream. Data
// bytes are split into nybbles, equal nybbles form runs of up to
// MAX_RUN_LENGTH, and every closed run is sent as its table code, or inline
// when the entry's length is zero. Output channel (code_valid, code_stall,
// code) carries the packed bytes, first bit in the MSB; last_of_run marks the
// final byte caused by an input item. End of stream sends the open run and
// the partial byte, and clears the run, the bit buffer and the XOR history.
// A data item is registered into the stage register together with its table
// reads; the packer then merges its runs into the bit buffer, and bytes
// leave through the output register. The packer takes the next item only
// once fewer than eight bits are pending and no final byte waits, and it
// shifts out an item's bytes (0 to 4) at one byte per cycle while the output
// is not stalled. A stalled output holds its byte; the packer then fills, the
// stage register fills, and item_stall rises. Reset clears control state,
// the history and the bit buffer; the stage, output and read-data registers
// keep no reset value, and the code table keeps no reset value and must be loaded.
`default_nettype none

module nybble_run_code_emitter_core
    import nrce_pkg::*;
#(
    parameter int MAX_RUN_LENGTH = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire in_item_t    item,
    output logic             code_valid,
    input  wire logic        code_stall,
    output out_item_t        code,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic xor_mode_reg, xor_mode_next;
    logic pad_reg, pad_next;
    logic cfg_write;

    logic                stage_take;
    logic                stage_valid;
    stage_t              stage;
    logic                mem_we;
    logic [TABLE_AW-1:0] mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [TABLE_AW-1:0] mem_raddr0;
    logic [TABLE_AW-1:0] mem_raddr1;
    logic [ENTRY_W-1:0]  rdata0;
    logic [ENTRY_W-1:0]  rdata1;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        xor_mode_next = xor_mode_reg;
        pad_next      = pad_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_XOR_MODE: xor_mode_next = pwdata[0];
                REG_PAD:      pad_next      = pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_XOR_MODE: prdata = {31'd0, xor_mode_reg};
            REG_PAD:      prdata = {31'd0, pad_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_mode_reg <= 1'b0;
            pad_reg      <= 1'b0;
        end
        else
        begin
            xor_mode_reg <= xor_mode_next;
            pad_reg      <= pad_next;
        end
    end

    nrce_run_tracker #(
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .xor_mode    (xor_mode_reg),
        .stage_take  (stage_take),
        .stage_valid (stage_valid),
        .stage       (stage),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr0  (mem_raddr0),
        .mem_raddr1  (mem_raddr1)
    );

    nrce_code_mem u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .re     (mem_re),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    nrce_packer u_packer (
        .clk            (clk),
        .rst_n          (rst_n),
        .pad_final_byte (pad_reg),
        .stage_valid    (stage_valid),
        .stage          (stage),
        .rdata0         (rdata0),
        .rdata1         (rdata1),
        .stage_take     (stage_take),
        .code_valid     (code_valid),
        .code_stall     (code_stall),
        .code           (code)
    );

endmodule

`default_nettype wire

// ===== rtl/nrce_code_mem.sv =====
`default_nettype none

module nrce_code_mem
    import nrce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [TABLE_AW-1:0] waddr,
    input  wire logic [ENTRY_W-1:0]  wdata,
    input  wire logic                re,
    input  wire logic [TABLE_AW-1:0] raddr0,
    input  wire logic [TABLE_AW-1:0] raddr1,
    output logic      [ENTRY_W-1:0]  rdata0,
    output logic      [ENTRY_W-1:0]  rdata1
);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rdata0_reg;
    logic [ENTRY_W-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

// ===== rtl/nrce_run_tracker.sv =====
`default_nettype none

module nrce_run_tracker
    import nrce_pkg::*;
#(
    parameter int MAX_RUN_LENGTH = 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire in_item_t            item,
    input  wire logic                xor_mode,
    input  wire logic                stage_take,
    output logic                     stage_valid,
    output stage_t                   stage,
    output logic                     mem_we,
    output logic      [TABLE_AW-1:0] mem_waddr,
    output logic      [ENTRY_W-1:0]  mem_wdata,
    output logic                     mem_re,
    output logic      [TABLE_AW-1:0] mem_raddr0,
    output logic      [TABLE_AW-1:0] mem_raddr1
);

    localparam logic [CNT_W-1:0] MaxLen = CNT_W'(MAX_RUN_LENGTH);

    logic [7:0]         hist_reg [HIST_DEPTH];
    logic [7:0]         hist_next [HIST_DEPTH];
    logic [HIST_AW-1:0] ptr_reg, ptr_next;
    logic [3:0]         digit_reg, digit_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               stage_vld_reg, stage_vld_next;
    stage_t             stage_reg, stage_next;

    logic               accept;
    logic               stage_load;
    logic [7:0]         value;
    step_t              step_hi;
    step_t              step_lo;

    assign item_stall = stage_vld_reg && !stage_take;
    assign accept     = item_valid && !item_stall;

    assign value   = item.data_byte ^ (xor_mode ? hist_reg[ptr_reg] : 8'h00);
    assign step_hi = nybble_step(digit_reg, count_reg, value[7:4], MaxLen);
    assign step_lo = nybble_step(step_hi.digit, step_hi.count, value[3:0], MaxLen);

    always_comb
    begin
        hist_next      = hist_reg;
        ptr_next       = ptr_reg;
        digit_next     = digit_reg;
        count_next     = count_reg;
        stage_next     = stage_reg;
        stage_load     = 1'b0;
        mem_we         = 1'b0;

        if (accept)
        begin
            case (item.func)
                FUNC_LOAD:
                begin
                    mem_we = 1'b1;
                end
                FUNC_DATA:
                begin
                    stage_load         = 1'b1;
                    hist_next[ptr_reg] = item.data_byte;
                    ptr_next           = ptr_reg + HIST_AW'(1);
                    digit_next         = step_lo.digit;
                    count_next         = step_lo.count;
                    stage_next.eos     = 1'b0;
                    stage_next.run0    = step_hi.evt;
                    stage_next.run1    = step_lo.evt;
                end
                FUNC_EOS:
                begin
                    stage_load             = 1'b1;
                    stage_next.eos         = 1'b1;
                    stage_next.run0.vld    = (count_reg != '0);
                    stage_next.run0.digit  = digit_reg;
                    stage_next.run0.len_m1 = 3'(count_reg - CNT_W'(1));
                    stage_next.run1        = '0;
                    for (int i = 0; i < HIST_DEPTH; i++)
                    begin
                        hist_next[i] = 8'h00;
                    end
                    ptr_next   = '0;
                    digit_next = 4'h0;
                    count_next = '0;
                end
                default:
                begin
                    // Unused code: the item is taken and dropped.
                end
            endcase
        end

        if (stage_load)
        begin
            stage_vld_next = 1'b1;
        end
        else if (stage_take)
        begin
            stage_vld_next = 1'b0;
        end
        else
        begin
            stage_vld_next = stage_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= 8'h00;
            end
            ptr_reg       <= '0;
            digit_reg     <= 4'h0;
            count_reg     <= '0;
            stage_vld_reg <= 1'b0;
        end
        else
        begin
            hist_reg      <= hist_next;
            ptr_reg       <= ptr_next;
            digit_reg     <= digit_next;
            count_reg     <= count_next;
            stage_vld_reg <= stage_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    // The table is read together with the stage load, so the read data and
    // the stage register always belong to the same item.
    assign mem_re      = stage_load;
    assign mem_raddr0  = {stage_next.run0.digit, stage_next.run0.len_m1};
    assign mem_raddr1  = {stage_next.run1.digit, stage_next.run1.len_m1};
    assign mem_waddr   = item.entry_index;
    assign mem_wdata   = {item.entry_code, item.entry_length};
    assign stage_valid = stage_vld_reg;
    assign stage       = stage_reg;

    a_open_run_short: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < MaxLen)
        else $error("open run reached the length limit without being sent");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_vld_reg && !stage_take |=> stage_vld_reg && $stable(stage_reg))
        else $error("stage register changed while the packer held it off");

endmodule

`default_nettype wire

// ===== rtl/nrce_packer.sv =====
`default_nettype none

module nrce_packer
    import nrce_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pad_final_byte,
    input  wire logic               stage_valid,
    input  wire stage_t             stage,
    input  wire logic [ENTRY_W-1:0] rdata0,
    input  wire logic [ENTRY_W-1:0] rdata1,
    output logic                    stage_take,
    output logic                    code_valid,
    input  wire logic               code_stall,
    output out_item_t               code
);

    typedef struct packed {
        logic [RUN_BITS_W-1:0] bits;
        logic [3:0]            len;
    } run_bits_t;

    // Turns a run into left-aligned code bits and a length: its table code, or inline when the entry length is 0.
    function automatic run_bits_t run_bits(run_evt_t e, logic [ENTRY_W-1:0] ent);
        run_bits_t   r;
        logic [3:0]  len;
        logic [15:0] tmp;
        r   = '0;
        len = ent[3:0];
        tmp = '0;
        if (e.vld)
        begin
            if (len == 4'd0)
            begin
                r.bits = {INLINE_PREFIX, e.len_m1, e.digit};
                r.len  = INLINE_LEN;
            end
            else
            begin
                if (len > MAX_CODE_LEN)
                begin
                    len = MAX_CODE_LEN;
                end
                tmp    = {8'h00, ent[11:4]} << (5'd16 - {1'b0, len});
                r.bits = tmp[15:3];
                r.len  = len;
            end
        end
        return r;
    endfunction

    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 flush_reg, flush_next;
    logic                 out_vld_reg, out_vld_next;
    out_item_t            out_reg, out_next;

    run_bits_t            rb0;
    run_bits_t            rb1;
    logic [ACC_W-1:0]     wide0;
    logic [ACC_W-1:0]     wide1;
    logic [ACC_CNT_W-1:0] total;
    logic [ACC_CNT_W-1:0] cnt_left;
    logic                 out_free;

    assign rb0      = run_bits(stage.run0, rdata0);
    assign rb1      = run_bits(stage.run1, rdata1);
    assign wide0    = {rb0.bits, (ACC_W - RUN_BITS_W)'(0)};
    assign wide1    = {rb1.bits, (ACC_W - RUN_BITS_W)'(0)};
    assign total    = cnt_reg + ACC_CNT_W'(rb0.len) + ACC_CNT_W'(rb1.len);
    assign cnt_left = cnt_reg - ACC_CNT_W'(8);
    assign out_free = !out_vld_reg || !code_stall;

    always_comb
    begin
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        flush_next   = flush_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && code_stall;
        stage_take   = 1'b0;

        if (cnt_reg >= ACC_CNT_W'(8))
        begin
            if (out_free)
            begin
                out_vld_next         = 1'b1;
                out_next.out_byte    = acc_reg[ACC_W-1 -: 8];
                out_next.last_of_run = (cnt_left < ACC_CNT_W'(8)) && !flush_reg;
                acc_next             = acc_reg << 8;
                cnt_next             = cnt_left;
            end
        end
        else if (flush_reg)
        begin
            // Final byte of a stream: pending bits left-aligned, zeros below.
            if (out_free)
            begin
                out_vld_next         = 1'b1;
                out_next.out_byte    = acc_reg[ACC_W-1 -: 8];
                out_next.last_of_run = 1'b1;
                acc_next             = '0;
                cnt_next             = '0;
                flush_next           = 1'b0;
            end
        end
        else if (stage_valid)
        begin
            stage_take = 1'b1;
            acc_next   = acc_reg | (wide0 >> cnt_reg)
                                 | (wide1 >> (cnt_reg + ACC_CNT_W'(rb0.len)));
            cnt_next   = total;
            flush_next = stage.eos && ((total[2:0] != 3'd0) || pad_final_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            cnt_reg     <= '0;
            flush_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            flush_reg   <= flush_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign code_valid = out_vld_reg;
    assign code       = out_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ACC_CNT_W'(33))
        else $error("bit buffer holds more bits than two runs and a partial byte");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> acc_reg == '0)
        else $error("empty bit buffer still holds set bits");

    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> cnt_reg <= ACC_CNT_W'(20))
        else $error("end of stream left more bits than one run and a partial byte");

endmodule

`default_nettype wire

// ===== dv/tb_nybble_run_code_emitter_core.sv =====
module tb_nybble_run_code_emitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import nrce_pkg::*;

    localparam int RUN_LIMIT       = 8;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int CYCLE_LIMIT     = 200000;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam logic [2:0] ADDR_XOR_MODE = {REG_XOR_MODE, 2'b00};
    localparam logic [2:0] ADDR_PAD      = {REG_PAD, 2'b00};

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    in_item_t    item       = '0;
    logic        code_valid;
    logic        code_stall = 1'b0;
    out_item_t   code;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;

    // Idle and stall percentages for the current phase.
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int hold_left    = 0;

    int cycle_count  = 0;
    int fail_count   = 0;
    int bytes_seen   = 0;
    int func_seen [4];

    // Predictor state, a copy of what the block holds.
    logic [11:0] run_code_table [TABLE_DEPTH];
    logic [7:0]  raw_history [HIST_DEPTH];
    logic [1:0]  history_slot = '0;
    logic [3:0]  run_digit    = '0;
    int          run_len      = 0;
    logic [6:0]  bit_buf      = '0;
    int          bit_cnt      = 0;
    logic        xor_on       = 1'b0;
    logic        pad_on       = 1'b0;
    logic [7:0]  last_data    = '0;
    out_item_t   expected_bytes [$];

    nybble_run_code_emitter_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Output side: a long hold-off takes priority over random stalls.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            code_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            code_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_code
        out_item_t want;
        if (rst_n && code_valid && !code_stall)
        begin
            bytes_seen++;
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte %02h arrived with nothing expected", code.out_byte);
                fail_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (code.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, code.out_byte);
                    fail_count++;
                end
                if (code.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, code.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    function automatic void queue_byte(logic [7:0] b);
        out_item_t o;
        o.out_byte    = b;
        o.last_of_run = 1'b0;
        expected_bytes.push_back(o);
    endfunction

    function automatic void pack_bit(logic b);
        logic [7:0] acc;
        acc = {bit_buf, b};
        if (bit_cnt >= 7)
        begin
            queue_byte(acc);
            bit_buf = '0;
            bit_cnt = 0;
        end
        else
        begin
            bit_buf = acc[6:0];
            bit_cnt++;
        end
    endfunction

    function automatic void emit_run(logic [3:0] digit, int len);
        logic [2:0]  len_m1;
        logic [11:0] entry;
        int          width;
        logic [12:0] inline_bits;
        len_m1 = 3'(len - 1);
        entry  = run_code_table[{digit, len_m1}];
        width  = entry[3:0];
        if (width != 0)
        begin
            // Lengths above a byte saturate; code bits above the length are dropped.
            if (width > 8)
                width = 8;
            for (int i = width - 1; i >= 0; i--)
                pack_bit(entry[4 + i]);
        end
        else
        begin
            inline_bits = {INLINE_PREFIX, len_m1, digit};
            for (int i = 12; i >= 0; i--)
                pack_bit(inline_bits[i]);
        end
    endfunction

    function automatic void add_digit(logic [3:0] n);
        if (run_len != 0 && n != run_digit)
        begin
            emit_run(run_digit, run_len);
            run_len = 0;
        end
        run_digit = n;
        run_len++;
        if (run_len >= RUN_LIMIT)
        begin
            emit_run(run_digit, run_len);
            run_len = 0;
        end
    endfunction

    function automatic void predict_codes(in_item_t it);
        int          start_depth;
        logic [7:0]  value;
        logic [7:0]  flush;
        out_item_t   tail;
        start_depth = expected_bytes.size();
        case (it.func)
            FUNC_LOAD:
                run_code_table[it.entry_index] = {it.entry_code, it.entry_length};
            FUNC_DATA:
            begin
                value = it.data_byte ^ (xor_on ? raw_history[history_slot] : 8'h00);
                raw_history[history_slot] = it.data_byte;
                history_slot++;
                add_digit(value[7:4]);
                add_digit(value[3:0]);
            end
            FUNC_EOS:
            begin
                if (run_len != 0)
                    emit_run(run_digit, run_len);
                run_len   = 0;
                run_digit = '0;
                if (bit_cnt != 0 || pad_on)
                begin
                    flush = {1'b0, bit_buf};
                    flush = flush << (8 - bit_cnt);
                    queue_byte(flush);
                end
                bit_buf = '0;
                bit_cnt = 0;
                foreach (raw_history[i])
                    raw_history[i] = '0;
                history_slot = '0;
            end
            default:
                ;
        endcase
        if (expected_bytes.size() > start_depth)
        begin
            tail = expected_bytes.pop_back();
            tail.last_of_run = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    function automatic in_item_t load_item(logic [6:0] idx, logic [7:0] bits, logic [3:0] len);
        in_item_t it;
        it              = '0;
        it.func         = FUNC_LOAD;
        it.entry_index  = idx;
        it.entry_code   = bits;
        it.entry_length = len;
        return it;
    endfunction

    function automatic in_item_t data_item(logic [7:0] b);
        in_item_t it;
        it           = '0;
        it.func      = FUNC_DATA;
        it.data_byte = b;
        return it;
    endfunction

    function automatic in_item_t end_item();
        in_item_t it;
        it      = '0;
        it.func = FUNC_EOS;
        return it;
    endfunction

    // Mostly data with plenty of repeats so that runs grow long; the rest are
    // table loads, stream ends and the unused function code.
    function automatic in_item_t random_item();
        in_item_t    it;
        logic [31:0] noise;
        logic [3:0]  nyb;
        int          pick;
        noise = $urandom;
        it    = noise[$bits(in_item_t)-1:0];
        pick  = $urandom_range(99);
        if (pick < 4)
            it.func = FUNC_EOS;
        else if (pick < 9)
            it.func = FUNC_LOAD;
        else if (pick < 11)
            it.func = FUNC_UNUSED;
        else
        begin
            it.func = FUNC_DATA;
            pick    = $urandom_range(9);
            if (pick >= 7)
                last_data = 8'($urandom);
            else if (pick >= 4)
            begin
                nyb       = 4'($urandom_range(15));
                last_data = {nyb, nyb};
            end
            it.data_byte = last_data;
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_codes(it);
        func_seen[it.func]++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        // Loads and ignored items leave no result behind but may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_XOR_MODE)
            xor_on = value;
        else
            pad_on = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_modes(logic xor_value, logic pad_value);
        write_register(ADDR_XOR_MODE, xor_value);
        write_register(ADDR_PAD, pad_value);
    endtask

    // Every entry is loaded before any run can look one up.
    task automatic load_code_table();
        for (int idx = 0; idx < TABLE_DEPTH; idx++)
            send_item(load_item(7'(idx), 8'($urandom), 4'($urandom_range(10))));
    endtask

    task automatic test_run_boundaries();
        in_item_t odd;
        odd      = '1;
        odd.func = FUNC_UNUSED;
        send_item(data_item(8'h00));
        send_item(data_item(8'hFF));
        send_item(data_item(8'hFF));
        send_item(data_item(8'hFF));
        send_item(data_item(8'hFF));
        send_item(data_item(8'h0F));
        send_item(data_item(8'hF0));
        send_item(end_item());
        send_item(end_item());
        send_item(odd);
        send_item(load_item({4'h5, 3'd0}, 8'hA5, 4'hF));
        send_item(load_item({4'hA, 3'd0}, 8'hFF, 4'd3));
        send_item(load_item({4'h3, 3'd1}, 8'h00, 4'd0));
        send_item(load_item(7'd127, 8'hFF, 4'd8));
        send_item(load_item(7'd0, 8'h00, 4'd1));
        send_item(data_item(8'h5A));
        send_item(data_item(8'h33));
        send_item(data_item(8'h0F));
        send_item(data_item(8'hFF));
        send_item(data_item(8'hFF));
        send_item(data_item(8'hFF));
        send_item(data_item(8'hF0));
        send_item(end_item());
    endtask

    task automatic test_pad_final_byte();
        wait_for_drain();
        set_modes(1'b0, 1'b1);
        send_item(end_item());
        send_item(data_item(8'h12));
        send_item(end_item());
    endtask

    task automatic test_xor_mode();
        wait_for_drain();
        set_modes(1'b1, 1'b0);
        repeat (2)
        begin
            send_item(data_item(8'h11));
            send_item(data_item(8'h22));
            send_item(data_item(8'h33));
            send_item(data_item(8'h44));
        end
        send_item(data_item(8'h5C));
        send_item(end_item());
        // History is clear after the stream end, so this byte goes through as is.
        send_item(data_item(8'h11));
        send_item(end_item());
    endtask

    task automatic test_random_traffic();
        int gap_pcts   [4] = '{0, 51, 0, 15};
        int stall_pcts [4] = '{0, 0, 51, 15};
        logic xor_vals [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
        logic pad_vals [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_for_drain();
            set_modes(xor_vals[ph], pad_vals[ph]);
            send_gap_pct = gap_pcts[ph];
            stall_pct    = stall_pcts[ph];
            repeat (3) send_item(random_item());
            send_item(end_item());
        end
        send_gap_pct = 0;
        stall_pct    = 0;
    endtask

    // The output holds off long enough for the block to fill and push back,
    // then the input waits for every byte before carrying on.
    task automatic test_backpressure();
        wait_for_drain();
        set_modes(1'b1, 1'b1);
        hold_left = HOLD_OFF_CYCLES;
        repeat (8) send_item(data_item(8'($urandom)));
        wait_for_drain();
        repeat (2) send_item(random_item());
        send_item(end_item());
    endtask

    initial
    begin
        foreach (raw_history[i])
            raw_history[i] = '0;
        foreach (func_seen[i])
            func_seen[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_code_table();
        test_run_boundaries();
        test_pad_final_byte();
        test_xor_mode();
        test_random_traffic();
        test_backpressure();
        wait_for_drain();

        $display("Sent %0d table loads, %0d data bytes, %0d stream ends, %0d unused codes;",
                 func_seen[FUNC_LOAD], func_seen[FUNC_DATA], func_seen[FUNC_EOS],
                 func_seen[FUNC_UNUSED]);
        $display("%0d bytes checked over XOR and padding modes in all combinations,",
                 bytes_seen);
        $display("four idle mixes and one long output hold-off.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
